### rtl/tfra_pkg.sv
// shared types and constants of the tagged fractional rate accumulator
package tfra_pkg;

    localparam int NUM_SLOTS = 32;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);

    // n / 236 by reciprocal: floor(2^39 / 236), exact to within one count for 32-bit inputs
    localparam logic [7:0]  DIVISOR     = 8'd236;
    localparam logic [31:0] RECIP       = 32'd2329473787;
    localparam int          RECIP_SHIFT = 39;
    // quotient of a 32-bit value by 236 fits in 25 bits
    localparam int          QUO_W       = 25;

    typedef struct packed {
        logic [4:0]         object_slot;
        logic [15:0]        object_id;
        logic [15:0]        rate;
        logic signed [15:0] direction;
        logic [15:0]        tick_count;
    } in_item_t;

    typedef struct packed {
        logic [31:0] velocity_delta;
    } out_item_t;

    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] dir;
        logic [7:0]  rem;
    } entry_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        entry_t            data;
    } wr_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DIV_HI,
        ST_WAIT_HI,
        ST_WAIT_LO,
        ST_FINISH
    } state_t;

endpackage

### rtl/tfra_stream_if.sv
// valid/ready stream channel carrying one payload item per transfer
interface tfra_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

### rtl/tfra_entry_store.sv
// per-slot accumulator entries: synchronous memory with valid bits for the reset value
module tfra_entry_store (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [tfra_pkg::SLOT_W-1:0] rd_addr,
    output tfra_pkg::entry_t          rd_entry,
    input  tfra_pkg::wr_req_t         wr
);
    import tfra_pkg::*;

    entry_t                mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  valid_reg;
    entry_t                rd_data_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // an entry never written reads as all zero
    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

endmodule

### rtl/tfra_div236.sv
// two-stage divider by 236: reciprocal estimate, then remainder check and correction
module tfra_div236 (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [31:0]                x,
    output logic                       done,
    output logic [tfra_pkg::QUO_W-1:0] quo,
    output logic [7:0]                 rem
);
    import tfra_pkg::*;

    logic             v1_reg;
    logic             v2_reg;
    logic [31:0]      x_reg;
    logic [QUO_W-1:0] q0_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [7:0]       rem_reg;

    logic [63:0]      prod;
    logic [31:0]      back;
    logic [8:0]       r0;

    assign prod = 64'(x) * 64'(RECIP);
    assign back = 32'(q0_reg) * 32'(DIVISOR);
    // estimate is exact or one short, so the raw remainder stays below twice the divisor
    assign r0   = 9'(x_reg - back);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg  <= x;
            q0_reg <= prod[RECIP_SHIFT +: QUO_W];
        end
        if (v1_reg)
        begin
            if (r0 >= 9'(DIVISOR))
            begin
                quo_reg <= q0_reg + QUO_W'(1);
                rem_reg <= 8'(r0 - 9'(DIVISOR));
            end
            else
            begin
                quo_reg <= q0_reg;
                rem_reg <= r0[7:0];
            end
        end
    end

    assign done = v2_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

### rtl/tagged_fractional_rate_accumulator_top.sv
// Tagged fractional rate accumulator: one result transfer per input transfer.
// Each item reads its slot's entry (id tag, direction, carried remainder) from a
// synchronous memory, retags or clears it, forms rate*ticks*65536 plus the
// remainder, divides by 236 and writes the new remainder back. Its steps are the
// memory read, the 16x16 multiply, and two passes through the shared divider by
// 236 (high part of the product, then its remainder joined with the low part),
// then write-back, with the result loaded into the output register once it is free.
// Items are handled one at a time, so no read can overtake a pending write.
// The output register lets the next item be accepted while a result waits.
// After reset all entries read as zero at once; there is no clearing pass.
module tagged_fractional_rate_accumulator_top (
    input  logic          clk,
    input  logic          rst_n,
    tfra_stream_if.sink   req,
    tfra_stream_if.source rsp
);
    import tfra_pkg::*;

    state_t            state_reg;
    state_t            state_next;

    logic [SLOT_W-1:0] slot_reg;
    logic              slot_ok_reg;
    logic [15:0]       id_reg;
    logic [15:0]       rate_reg;
    logic [15:0]       dir_reg;
    logic [15:0]       ticks_reg;

    entry_t            rd_entry;
    entry_t            fresh;
    entry_t            cur_reg;
    logic [7:0]        rem_eff_reg;
    logic [31:0]       prod_reg;
    logic [15:0]       hi_reg;
    logic [QUO_W-1:0]  lo_q_reg;
    logic [7:0]        rem_new_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [31:0]       out_data_reg;

    logic              accept;
    logic              load_out;
    logic              div_start;
    logic [31:0]       div_x;
    logic              div_done;
    logic [QUO_W-1:0]  div_quo;
    logic [7:0]        div_rem;
    wr_req_t           wr;

    assign accept = req.valid && req.ready;

    tfra_entry_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (SLOT_W'(req.payload.object_slot)),
        .rd_entry (rd_entry),
        .wr       (wr)
    );

    tfra_div236 u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .x     (div_x),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    // retag clears the whole entry, then a direction change clears the remainder
    always_comb
    begin
        fresh = rd_entry;
        if (fresh.tag != id_reg)
        begin
            fresh.tag = id_reg;
            fresh.dir = '0;
            fresh.rem = '0;
        end
        if (fresh.dir != dir_reg)
        begin
            fresh.dir = dir_reg;
            fresh.rem = '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        div_start  = 1'b0;
        div_x      = prod_reg;
        load_out   = 1'b0;
        wr.en      = 1'b0;
        wr.addr    = slot_reg;
        wr.data    = '{tag: cur_reg.tag, dir: cur_reg.dir, rem: rem_new_reg};
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_DIV_HI;
            end
            ST_DIV_HI:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT_HI;
            end
            ST_WAIT_HI:
            begin
                // second pass: (prod mod 236) * 65536 + carried remainder
                div_x = {8'h00, div_rem, 8'h00, rem_eff_reg};
                if (div_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_WAIT_LO;
                end
            end
            ST_WAIT_LO:
            begin
                if (div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    wr.en      = slot_ok_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg    <= SLOT_W'(req.payload.object_slot);
            slot_ok_reg <= 32'(req.payload.object_slot) < 32'(NUM_SLOTS);
            id_reg      <= req.payload.object_id;
            rate_reg    <= req.payload.rate;
            dir_reg     <= req.payload.direction;
            ticks_reg   <= req.payload.tick_count;
        end
        if (state_reg == ST_LOOKUP)
        begin
            cur_reg     <= fresh;
            rem_eff_reg <= slot_ok_reg ? fresh.rem : 8'h00;
            prod_reg    <= 32'(rate_reg) * 32'(ticks_reg);
        end
        if ((state_reg == ST_WAIT_HI) && div_done)
        begin
            // only the low 16 bits of the high quotient survive the 32-bit wrap
            hi_reg <= div_quo[15:0];
        end
        if ((state_reg == ST_WAIT_LO) && div_done)
        begin
            lo_q_reg    <= div_quo;
            rem_new_reg <= div_rem;
        end
        if (load_out)
        begin
            out_data_reg <= {hi_reg, 16'h0000} + 32'(lo_q_reg);
        end
    end

    assign rsp.valid                  = out_valid_reg;
    assign rsp.payload.velocity_delta = out_data_reg;

endmodule

### tb/tagged_fractional_rate_accumulator_top_test.sv
`timescale 1ns / 100ps
// testbench of the tagged fractional rate accumulator: random traffic checked against a predictor
module tagged_fractional_rate_accumulator_top_test;

    import tfra_pkg::*;

    localparam int          CYCLE_LIMIT  = 800000;
    localparam int          RANDOM_ITEMS = 1500;
    localparam int          POOL_SIZE    = 12;
    localparam int          SHOW_LIMIT   = 10;
    localparam logic [63:0] DIV_BY       = 64'd236;
    localparam logic [63:0] SUBUNIT      = 64'd65536;

    logic clk = 1'b0;
    logic rst_n;

    tfra_stream_if #(.payload_t(in_item_t))  req_if ();
    tfra_stream_if #(.payload_t(out_item_t)) rsp_if ();

    tagged_fractional_rate_accumulator_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // predictor state: one entry per slot
    logic [15:0] tag_mem [NUM_SLOTS];
    logic [15:0] dir_mem [NUM_SLOTS];
    logic [7:0]  rem_mem [NUM_SLOTS];

    in_item_t    item_queue [$];
    logic [31:0] expected_deltas [$];

    int          items_sent;
    int          results_seen;
    int          mismatches;
    int          retags;
    int          turns;
    int          carries;
    int          cycle_count;

    // driver state
    int          gap_left;
    bit          send_calm;
    bit          drv_fire;
    logic        next_valid;

    // receiver state
    int          stall_left;
    bit          recv_calm;
    logic        next_ready;
    logic [31:0] want_delta;

    // long hold-off of the receiver
    logic        choke;
    bit          choke_done;
    int          choke_cycles;

    // random object pool for well-formed sequences
    logic [4:0]  obj_slot [POOL_SIZE];
    logic [15:0] obj_id   [POOL_SIZE];
    logic [15:0] obj_dir  [POOL_SIZE];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] accumulate_delta(input in_item_t it);
        logic [63:0] num;
        logic [63:0] quo;
        logic [7:0]  carried;
        int          idx;
        carried = '0;
        idx = it.object_slot;
        if (idx < NUM_SLOTS)
        begin
            if (tag_mem[idx] != it.object_id)
            begin
                tag_mem[idx] = it.object_id;
                dir_mem[idx] = '0;
                rem_mem[idx] = '0;
                retags++;
            end
            if (dir_mem[idx] != it.direction)
            begin
                dir_mem[idx] = it.direction;
                rem_mem[idx] = '0;
                turns++;
            end
            carried = rem_mem[idx];
            if (carried != 0)
                carries++;
        end
        num = 64'(it.rate) * 64'(it.tick_count) * SUBUNIT + 64'(carried);
        if (idx < NUM_SLOTS)
            rem_mem[idx] = 8'(num % DIV_BY);
        quo = num / DIV_BY;
        return quo[31:0];
    endfunction

    task automatic add_item(input logic [4:0] slot, input logic [15:0] id,
                            input logic [15:0] rate, input logic [15:0] dir,
                            input logic [15:0] ticks);
        in_item_t it;
        it.object_slot = slot;
        it.object_id   = id;
        it.rate        = rate;
        it.direction   = dir;
        it.tick_count  = ticks;
        item_queue.push_back(it);
    endtask

    function automatic logic [15:0] pick_amount();
        logic [15:0] v;
        case ($urandom_range(3))
            0: v = 16'($urandom_range(15));
            1:
            begin
                case ($urandom_range(3))
                    0: v = 16'h0000;
                    1: v = 16'hffff;
                    2: v = 16'h8000;
                    default: v = 16'h0001;
                endcase
            end
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    function automatic int pick_wait();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 12);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
            $display("mismatch at result %0d: %s, expected %08h, got %08h",
                     results_seen, what, want, got);
    endtask

    // driver: offers the pending items, with gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            drv_fire = req_if.valid && req_if.ready;
            if (drv_fire)
            begin
                expected_deltas.push_back(accumulate_delta(req_if.payload));
                items_sent++;
                if ($urandom_range(199) == 0)
                    send_calm = !send_calm;
            end
            if (!req_if.valid || drv_fire)
            begin
                next_valid = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (item_queue.size() > 0)
                begin
                    req_if.payload <= item_queue.pop_front();
                    next_valid = 1'b1;
                    gap_left = send_calm ? 0 : pick_wait();
                end
                req_if.valid <= next_valid;
            end
        end
    end

    // monitor: checks every result transfer and paces the receiver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                results_seen++;
                if (expected_deltas.size() == 0)
                    report_mismatch("result with nothing outstanding", '0,
                                    rsp_if.payload.velocity_delta);
                else
                begin
                    want_delta = expected_deltas.pop_front();
                    if (rsp_if.payload.velocity_delta !== want_delta)
                        report_mismatch("velocity_delta", want_delta,
                                        rsp_if.payload.velocity_delta);
                end
                if ($urandom_range(199) == 0)
                    recv_calm = !recv_calm;
            end
            if (choke)
                next_ready = 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                next_ready = 1'b0;
            end
            else if (recv_calm)
                next_ready = 1'b1;
            else
            begin
                stall_left = pick_wait();
                next_ready = (stall_left == 0);
            end
            rsp_if.ready <= next_ready;
        end
    end

    // one long hold-off once traffic is under way, so the block backs up
    always @(posedge clk)
    begin
        if (rst_n && !choke_done)
        begin
            if (!choke && results_seen >= 300)
            begin
                choke <= 1'b1;
                choke_cycles <= 0;
            end
            else if (choke)
            begin
                choke_cycles <= choke_cycles + 1;
                if (choke_cycles == 400)
                begin
                    choke <= 1'b0;
                    choke_done <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles with %0d of %0d results seen",
                     cycle_count, results_seen, items_sent);
            $display("tagged_fractional_rate_accumulator_top_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        int          k;
        int          roll;
        logic [15:0] rate;
        logic [15:0] ticks;

        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
        items_sent     = 0;
        results_seen   = 0;
        mismatches     = 0;
        retags         = 0;
        turns          = 0;
        carries        = 0;
        cycle_count    = 0;
        gap_left       = 0;
        send_calm      = 1'b0;
        stall_left     = 0;
        recv_calm      = 1'b0;
        choke          = 1'b0;
        choke_done     = 1'b0;
        choke_cycles   = 0;
        for (k = 0; k < NUM_SLOTS; k++)
        begin
            tag_mem[k] = '0;
            dir_mem[k] = '0;
            rem_mem[k] = '0;
        end

        // fresh entry with id zero, then a carried remainder on it
        add_item(5'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        add_item(5'd0, 16'h0000, 16'h0001, 16'h0000, 16'h0001);
        add_item(5'd0, 16'h0000, 16'h0001, 16'h0000, 16'h0001);
        add_item(5'd0, 16'h0000, 16'h0003, 16'h0000, 16'h0007);
        // largest product, quotient wraps
        add_item(5'd31, 16'hffff, 16'hffff, 16'h7fff, 16'hffff);
        add_item(5'd31, 16'hffff, 16'hffff, 16'h7fff, 16'hffff);
        add_item(5'd31, 16'hffff, 16'hffff, 16'h8000, 16'hffff);
        add_item(5'd31, 16'hffff, 16'h0001, 16'h8000, 16'h0001);
        // retag and direction change together
        add_item(5'd5, 16'h1234, 16'h00ff, 16'hffff, 16'h0013);
        add_item(5'd5, 16'h1234, 16'h00ff, 16'hffff, 16'h0013);
        add_item(5'd5, 16'h1234, 16'h00ff, 16'h0000, 16'h0013);
        // retag to a new id with direction zero, the cleared value
        add_item(5'd5, 16'h0063, 16'h00ff, 16'h0000, 16'h0013);
        // fresh entry, id zero, non-zero direction
        add_item(5'd6, 16'h0000, 16'h0011, 16'h0005, 16'h0022);
        add_item(5'd6, 16'h0000, 16'h0011, 16'h0005, 16'h0022);
        // one operand at an extreme, the other at one or zero
        add_item(5'd7, 16'h5555, 16'hffff, 16'haaaa, 16'h0001);
        add_item(5'd7, 16'h5555, 16'h0001, 16'haaaa, 16'hffff);
        add_item(5'd7, 16'h5555, 16'h0000, 16'haaaa, 16'hffff);
        add_item(5'd7, 16'h5555, 16'hffff, 16'haaaa, 16'h0000);
        add_item(5'd16, 16'h8000, 16'h8000, 16'h8001, 16'h8000);
        add_item(5'd16, 16'h8000, 16'h8000, 16'h8001, 16'h8000);

        for (k = 0; k < POOL_SIZE; k++)
        begin
            obj_slot[k] = 5'($urandom_range(31));
            obj_id[k]   = 16'($urandom);
            obj_dir[k]  = ($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            k     = $urandom_range(POOL_SIZE - 1);
            roll  = $urandom_range(99);
            rate  = pick_amount();
            ticks = pick_amount();
            if (roll < 10)
                obj_dir[k] = ($urandom_range(4) == 0) ? 16'h0000 : 16'($urandom);
            else if (roll < 15)
            begin
                obj_id[k] = 16'($urandom);
                if ($urandom_range(1) == 0)
                    obj_dir[k] = 16'($urandom);
            end
            if (roll < 88)
                add_item(obj_slot[k], obj_id[k], rate, obj_dir[k], ticks);
            else
                add_item(5'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom));
        end

        repeat (11) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (item_queue.size() != 0 || req_if.valid)
            @(posedge clk);
        while (expected_deltas.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("%0d items sent, %0d results checked, %0d mismatches",
                 items_sent, results_seen, mismatches);
        $display("%0d retags, %0d direction changes, %0d updates with a carried remainder",
                 retags, turns, carries);
        if (mismatches == 0 && expected_deltas.size() == 0 && results_seen == items_sent)
            $display("tagged_fractional_rate_accumulator_top_test OK");
        else
            $display("tagged_fractional_rate_accumulator_top_test NOT OK");
        $finish;
    end

endmodule
